[rtl/chd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int SIZE_WIDTH = 32;
    localparam int DIGIT_CAP_RAW = SIZE_WIDTH / 4;
    localparam int DIGIT_CAP = (DIGIT_CAP_RAW > 15) ? 15 : DIGIT_CAP_RAW;

    localparam logic [3:0] MAX_DIGITS_RESET = 4'd8;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] EV_DATA  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [1:0] TM_NONE  = 2'd0;
    localparam logic [1:0] TM_CR    = 2'd1;
    localparam logic [1:0] TM_CRLF  = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

    typedef enum logic [7:0] {
        PH_SIZE    = 8'b0000_0001,
        PH_SIZE_CR = 8'b0000_0010,
        PH_DATA    = 8'b0000_0100,
        PH_DATA_CR = 8'b0000_1000,
        PH_DATA_LF = 8'b0001_0000,
        PH_TRAILER = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] ev;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Effective digit limit: zero acts as one, and the size register caps it.
    function automatic logic [3:0] digit_limit(input logic [3:0] cfg);
        logic [3:0] lim;
        lim = (cfg == 4'd0) ? 4'd1 : cfg;
        if (lim > 4'(DIGIT_CAP))
        begin
            lim = 4'(DIGIT_CAP);
        end
        return lim;
    endfunction

endpackage
`default_nettype wire

[rtl/http_chunked_body_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked message body one byte per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one body byte, or a connection
// close flag, per request. Output channel (out_valid/out_ready) carries a
// payload byte, a body-complete event or an error event; size lines, CR LF
// delimiters and trailers produce nothing.
// Each request lands in an input register, is decoded against the parser state
// and its result is captured in an output register once that register is free
// or drains. One request is taken every cycle while the receiver keeps up; the
// parser state update is the only loop.
// When the receiver stalls, the held result waits in the output register and
// the input register still takes one more request; after that in_ready drops
// until out_ready returns.
// Reset clears both valid flags, puts the parser at the start of a size line
// and sets the digit limit to eight. cfg_we writes the digit limit; the user
// must write it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] body_byte,
    input  wire logic       peer_closed,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      event_res,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data
);

    logic              held_valid_reg;
    logic [7:0]        held_byte_reg;
    logic              held_closed_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [1:0]        event_reg;
    logic [3:0]        max_digits_reg;
    logic [3:0]        limit;
    logic              advance;
    chd_pkg::result_t  result;

    // The held request moves on whenever the output register is free or drains.
    assign advance  = held_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !held_valid_reg || advance;
    assign limit    = chd_pkg::digit_limit(max_digits_reg);

    chd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .body_byte   (held_byte_reg),
        .peer_closed (held_closed_reg),
        .limit       (limit),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_digits_reg <= chd_pkg::MAX_DIGITS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                held_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= result.valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                max_digits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            held_byte_reg   <= body_byte;
            held_closed_reg <= peer_closed;
        end
        if (advance && result.valid)
        begin
            out_byte_reg <= result.data;
            event_reg    <= result.ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign event_res = event_reg;

endmodule
`default_nettype wire

[rtl/chd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chd_core
// Parser state and per-byte next-state logic of the chunked body decoder.
// ----------------------------------------------------------------------------
module chd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       body_byte,
    input  wire logic             peer_closed,
    input  wire logic [3:0]       limit,
    output chd_pkg::result_t      result
);

    chd_pkg::phase_t                    phase_reg, phase_next;
    logic [chd_pkg::SIZE_WIDTH-1:0]     left_reg, left_next;
    logic [3:0]                         count_reg, count_next;
    logic                               ended_reg, ended_next;
    logic [1:0]                         tmatch_reg, tmatch_next;
    logic [chd_pkg::SIZE_WIDTH-1:0]     left_dec;
    chd_pkg::hex_t                      hex;

    assign hex      = chd_pkg::hex_decode(body_byte);
    assign left_dec = left_reg - chd_pkg::SIZE_WIDTH'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        count_next  = count_reg;
        ended_next  = ended_reg;
        tmatch_next = tmatch_reg;
        result      = '{valid: 1'b0, data: 8'd0, ev: chd_pkg::EV_DATA};

        if (phase_reg == chd_pkg::PH_DONE || phase_reg == chd_pkg::PH_ERROR)
        begin
            // Terminal states swallow everything.
        end
        else if (peer_closed)
        begin
            phase_next = chd_pkg::PH_ERROR;
            result     = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_ERROR};
        end
        else
        begin
            case (phase_reg)
                chd_pkg::PH_SIZE:
                begin
                    if (!ended_reg && hex.valid)
                    begin
                        if (count_reg >= limit)
                        begin
                            phase_next = chd_pkg::PH_ERROR;
                            result = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_ERROR};
                        end
                        else
                        begin
                            count_next = count_reg + 4'd1;
                            left_next  = {left_reg[chd_pkg::SIZE_WIDTH-5:0], hex.value};
                        end
                    end
                    else if (!ended_reg && count_reg == 4'd0)
                    begin
                        phase_next = chd_pkg::PH_ERROR;
                        result = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_ERROR};
                    end
                    else
                    begin
                        ended_next = 1'b1;
                        if (body_byte == chd_pkg::CH_CR)
                        begin
                            phase_next = chd_pkg::PH_SIZE_CR;
                        end
                    end
                end
                chd_pkg::PH_SIZE_CR:
                begin
                    if (body_byte == chd_pkg::CH_LF)
                    begin
                        if (left_reg == '0)
                        begin
                            phase_next  = chd_pkg::PH_TRAILER;
                            tmatch_next = chd_pkg::TM_CRLF;
                        end
                        else
                        begin
                            phase_next = chd_pkg::PH_DATA;
                        end
                    end
                    else if (body_byte != chd_pkg::CH_CR)
                    begin
                        phase_next = chd_pkg::PH_SIZE;
                    end
                end
                chd_pkg::PH_DATA:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = chd_pkg::PH_DATA_CR;
                    end
                    result = '{valid: 1'b1, data: body_byte, ev: chd_pkg::EV_DATA};
                end
                chd_pkg::PH_DATA_CR:
                begin
                    if (body_byte != chd_pkg::CH_CR)
                    begin
                        phase_next = chd_pkg::PH_ERROR;
                        result = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_ERROR};
                    end
                    else
                    begin
                        phase_next = chd_pkg::PH_DATA_LF;
                    end
                end
                chd_pkg::PH_DATA_LF:
                begin
                    if (body_byte != chd_pkg::CH_LF)
                    begin
                        phase_next = chd_pkg::PH_ERROR;
                        result = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_ERROR};
                    end
                    else
                    begin
                        phase_next = chd_pkg::PH_SIZE;
                        left_next  = '0;
                        count_next = 4'd0;
                        ended_next = 1'b0;
                    end
                end
                chd_pkg::PH_TRAILER:
                begin
                    if (body_byte == chd_pkg::CH_CR)
                    begin
                        tmatch_next = (tmatch_reg == chd_pkg::TM_CRLF) ?
                                      chd_pkg::TM_CRLFCR : chd_pkg::TM_CR;
                    end
                    else if (body_byte == chd_pkg::CH_LF)
                    begin
                        if (tmatch_reg == chd_pkg::TM_CRLFCR)
                        begin
                            phase_next  = chd_pkg::PH_DONE;
                            tmatch_next = chd_pkg::TM_NONE;
                            result = '{valid: 1'b1, data: 8'd0, ev: chd_pkg::EV_DONE};
                        end
                        else
                        begin
                            tmatch_next = (tmatch_reg == chd_pkg::TM_CR) ?
                                          chd_pkg::TM_CRLF : chd_pkg::TM_NONE;
                        end
                    end
                    else
                    begin
                        tmatch_next = chd_pkg::TM_NONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= chd_pkg::PH_SIZE;
            left_reg   <= '0;
            count_reg  <= 4'd0;
            ended_reg  <= 1'b0;
            tmatch_reg <= chd_pkg::TM_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            count_reg  <= count_next;
            ended_reg  <= ended_next;
            tmatch_reg <= tmatch_next;
        end
    end

endmodule
`default_nettype wire

[tb/chunk_decode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_decode_checker
// Watches both handshake channels of the chunked body decoder, tracks the
// parser on every accepted body byte and compares each result it returns.
// ----------------------------------------------------------------------------
module chunk_decode_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] body_byte,
    input  wire logic       peer_closed,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic [1:0] event_res,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data,
    output int              fail_count,
    output int              due_count
);

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
    } decoded_t;

    decoded_t                       decoded_q[$];
    chd_pkg::phase_t                ph;
    logic [chd_pkg::SIZE_WIDTH-1:0] chunk_count;
    logic [3:0]                     ndigits;
    logic                           size_over;
    logic [1:0]                     crlf_seen;
    logic [3:0]                     limit_reg;
    int                             fails = 0;
    int                             due = 0;

    assign fail_count = fails;
    assign due_count  = due;

    task automatic report_fail(input string what);
        // Keep the log short if the block is badly broken; every failure still counts.
        if (fails < 50)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fails++;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 48;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c) - 87;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c) - 55;
        end
        return -1;
    endfunction

    // A limit of zero behaves as one, and the size register width caps it.
    function automatic logic [3:0] allowed_digits();
        logic [3:0] lim;
        lim = (limit_reg == 4'd0) ? 4'd1 : limit_reg;
        if (lim > 4'(chd_pkg::DIGIT_CAP))
        begin
            lim = 4'(chd_pkg::DIGIT_CAP);
        end
        return lim;
    endfunction

    task automatic note_result(input logic [7:0] d, input logic [1:0] ev);
        decoded_t r;
        r.ev = ev;
        r.data = d;
        decoded_q.push_back(r);
    endtask

    task automatic enter_error();
        ph = chd_pkg::PH_ERROR;
        note_result(8'h00, chd_pkg::EV_ERROR);
    endtask

    task automatic begin_size_line();
        ph = chd_pkg::PH_SIZE;
        chunk_count = '0;
        ndigits = 4'd0;
        size_over = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic closed);
        int nib;
        if (ph == chd_pkg::PH_DONE || ph == chd_pkg::PH_ERROR)
        begin
            return;
        end
        if (closed)
        begin
            enter_error();
            return;
        end
        case (ph)
            chd_pkg::PH_SIZE:
            begin
                if (!size_over)
                begin
                    nib = hex_nibble(c);
                    if (nib >= 0)
                    begin
                        if (ndigits >= allowed_digits())
                        begin
                            enter_error();
                            return;
                        end
                        ndigits = ndigits + 4'd1;
                        chunk_count = {chunk_count[chd_pkg::SIZE_WIDTH-5:0], 4'(nib)};
                        return;
                    end
                    if (ndigits == 4'd0)
                    begin
                        enter_error();
                        return;
                    end
                    size_over = 1'b1;
                end
                if (c == chd_pkg::CH_CR)
                begin
                    ph = chd_pkg::PH_SIZE_CR;
                end
            end
            chd_pkg::PH_SIZE_CR:
            begin
                if (c == chd_pkg::CH_LF)
                begin
                    if (chunk_count == '0)
                    begin
                        // The size line's own CR LF already counts toward the end.
                        ph = chd_pkg::PH_TRAILER;
                        crlf_seen = chd_pkg::TM_CRLF;
                    end
                    else
                    begin
                        ph = chd_pkg::PH_DATA;
                    end
                end
                else if (c != chd_pkg::CH_CR)
                begin
                    ph = chd_pkg::PH_SIZE;
                end
            end
            chd_pkg::PH_DATA:
            begin
                chunk_count = chunk_count - chd_pkg::SIZE_WIDTH'(1);
                if (chunk_count == '0)
                begin
                    ph = chd_pkg::PH_DATA_CR;
                end
                note_result(c, chd_pkg::EV_DATA);
            end
            chd_pkg::PH_DATA_CR:
            begin
                if (c != chd_pkg::CH_CR)
                begin
                    enter_error();
                end
                else
                begin
                    ph = chd_pkg::PH_DATA_LF;
                end
            end
            chd_pkg::PH_DATA_LF:
            begin
                if (c != chd_pkg::CH_LF)
                begin
                    enter_error();
                end
                else
                begin
                    begin_size_line();
                end
            end
            default:
            begin
                if (c == chd_pkg::CH_CR)
                begin
                    crlf_seen = (crlf_seen == chd_pkg::TM_CRLF) ? chd_pkg::TM_CRLFCR
                                                                : chd_pkg::TM_CR;
                end
                else if (c == chd_pkg::CH_LF)
                begin
                    if (crlf_seen == chd_pkg::TM_CRLFCR)
                    begin
                        ph = chd_pkg::PH_DONE;
                        crlf_seen = chd_pkg::TM_NONE;
                        note_result(8'h00, chd_pkg::EV_DONE);
                    end
                    else
                    begin
                        crlf_seen = (crlf_seen == chd_pkg::TM_CR) ? chd_pkg::TM_CRLF
                                                                  : chd_pkg::TM_NONE;
                    end
                end
                else
                begin
                    crlf_seen = chd_pkg::TM_NONE;
                end
            end
        endcase
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            report_fail($sformatf("unexpected result, byte %02h event %0d",
                                  out_byte, event_res));
        end
        else
        begin
            want = decoded_q.pop_front();
            if (event_res !== want.ev)
            begin
                report_fail($sformatf("event %0d, expected %0d", event_res, want.ev));
            end
            if (out_byte !== want.data)
            begin
                report_fail($sformatf("byte %02h, expected %02h", out_byte, want.data));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_q.delete();
            limit_reg = chd_pkg::MAX_DIGITS_RESET;
            begin_size_line();
            crlf_seen = chd_pkg::TM_NONE;
            due = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                decode_byte(body_byte, peer_closed);
            end
            due = decoded_q.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams one long chunked body through the decoder: a few hand-built chunks,
// then random chunks under several digit limits, then one randomly chosen way
// of ending the body (completion or an error) followed by ignored bytes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT        = 400;
    localparam int PHASE_ITEMS    = 160;
    localparam int NUM_PHASES     = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] body_byte = 8'h00;
    logic       peer_closed = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] event_res;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_data = 4'd0;

    int fail_count;
    int due_count;
    int taken_count = 0;
    int stall_cycles = 0;
    int burst_left = 0;
    int sent_count = 0;
    int digit_lim = 8;

    always #6 clk = ~clk;

    http_chunked_body_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .body_byte   (body_byte),
        .peer_closed (peer_closed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .event_res   (event_res),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    chunk_decode_checker u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .body_byte   (body_byte),
        .peer_closed (peer_closed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .event_res   (event_res),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .due_count   (due_count)
    );

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            taken_count <= taken_count + 1;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stretches of differing readiness, plus one long hold-off that
    // lets the decoder fill up and push back on the input side.
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && taken_count >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(5, 60);
                repeat (span)
                begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic closed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        body_byte <= b;
        peer_closed <= closed;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    // Wait until every result has been returned, then let bytes that give no
    // result clear the pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        digit_lim = (v == 4'd0) ? 1 : int'(v);
        if (digit_lim > chd_pkg::DIGIT_CAP)
        begin
            digit_lim = chd_pkg::DIGIT_CAP;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + nib;
        end
        return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 47));
            1: return 8'($urandom_range(58, 64));
            2: return 8'($urandom_range(71, 96));
            default: return 8'($urandom_range(103, 255));
        endcase
    endfunction

    // Extension text: anything but LF, so a CR inside it never ends the line.
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == chd_pkg::CH_LF) ? chd_pkg::CH_CR : b;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == chd_pkg::CH_CR || b == chd_pkg::CH_LF) ? (b | 8'h20) : b;
    endfunction

    task automatic send_size_line(input int unsigned size, input int ndig);
        int k;
        int n;
        for (k = ndig - 1; k >= 0; k--)
        begin
            push_byte(hex_char(4'(size >> (4 * k))), 1'b0);
        end
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 4))
            0: n = 0;
            1: push_byte(8'h3B, 1'b0);
            2: push_byte(($urandom_range(0, 1) == 1) ? 8'h20 : 8'h09, 1'b0);
            default: push_byte(non_hex(), 1'b0);
        endcase
        repeat (n) push_byte(line_byte(), 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);
    endtask

    task automatic send_chunk(input int unsigned size);
        int need;
        need = 1;
        while (need < 8 && (size >> (4 * need)) != 0)
        begin
            need++;
        end
        send_size_line(size, $urandom_range(need, digit_lim));
        repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);
    endtask

    function automatic int unsigned random_size();
        int unsigned top_size;
        top_size = (digit_lim == 1) ? 15 : 48;
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(1, top_size);
        end
        return $urandom_range(1, 8);
    endfunction

    initial
    begin
        int p;
        int start_count;
        int size;
        logic [3:0] lim_val;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Eight digits with leading zeros at the reset limit, then one byte.
        repeat (7) push_byte(8'h30, 1'b0);
        push_byte(8'h31, 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);
        // Size ended by a space, with a lone CR inside the extension text.
        push_byte(8'h32, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(8'h7A, 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(chd_pkg::CH_CR, 1'b0);
        push_byte(chd_pkg::CH_LF, 1'b0);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: lim_val = 4'd0;
                1: lim_val = 4'd15;
                2: lim_val = 4'd1;
                3: lim_val = 4'd8;
                default: lim_val = 4'($urandom_range(0, 15));
            endcase
            drain();
            set_limit(lim_val);
            start_count = sent_count;
            while (sent_count - start_count < PHASE_ITEMS)
            begin
                send_chunk(random_size());
            end
        end

        case ($urandom_range(0, 6))
            0:
            begin
                // Zero size closed at once by an empty line.
                send_size_line(0, $urandom_range(1, digit_lim));
                push_byte(chd_pkg::CH_CR, 1'b0);
                push_byte(chd_pkg::CH_LF, 1'b0);
            end
            1:
            begin
                send_size_line(0, $urandom_range(1, digit_lim));
                repeat ($urandom_range(1, 2))
                begin
                    repeat ($urandom_range(1, 10)) push_byte(text_byte(), 1'b0);
                    push_byte(chd_pkg::CH_CR, 1'b0);
                    push_byte(chd_pkg::CH_LF, 1'b0);
                end
                push_byte(chd_pkg::CH_CR, 1'b0);
                push_byte(chd_pkg::CH_LF, 1'b0);
            end
            2:
            begin
                // Trailer noise rich in stray CRs and LFs.
                send_size_line(0, $urandom_range(1, digit_lim));
                repeat ($urandom_range(4, 20))
                begin
                    case ($urandom_range(0, 3))
                        0: push_byte(chd_pkg::CH_CR, 1'b0);
                        1: push_byte(chd_pkg::CH_LF, 1'b0);
                        default: push_byte(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
                repeat (2)
                begin
                    push_byte(chd_pkg::CH_CR, 1'b0);
                    push_byte(chd_pkg::CH_LF, 1'b0);
                end
            end
            3: push_byte(non_hex(), 1'b0);
            4: repeat (digit_lim + 1) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            5:
            begin
                size = $urandom_range(1, 4);
                send_size_line(size, 1);
                repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 1)
                begin
                    push_byte(chd_pkg::CH_CR, 1'b0);
                end
                push_byte(text_byte(), 1'b0);
            end
            default:
            begin
                send_size_line(3, 1);
                push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase

        // Once the body has ended, nothing more may come out.
        repeat (12) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        drain();
        repeat (6) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[http_chunked_body_decoder.f]
rtl/chd_pkg.sv
rtl/chd_core.sv
rtl/http_chunked_body_decoder.sv
tb/chunk_decode_checker.sv
tb/testbench.sv
